// ----- rtl/vna_pkg.sv -----
// Shared types and constants of the vertex normal accumulator.
package vna_pkg;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 10;
  localparam int POS_W   = 20;
  localparam int POS_EXT = 24;
  localparam int VCNT_W  = 11;
  localparam int LIM_W   = 17;
  localparam int SUM_W   = 56;
  localparam int NORM_W  = 16;
  localparam int T_W     = 30;
  localparam int FRAC_Q  = 14;
  localparam int QUO_W   = 15;
  localparam int SQ_W    = 64;
  localparam int LEN_W   = 31;
  localparam int DV_W    = 46;
  localparam int CNT_W   = 3;

  localparam logic [NORM_W-1:0] ONE_Q14 = NORM_W'(16384);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_TRI   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_TRI_RD,
    S_TRI_DIFF,
    S_TRI_MUL,
    S_SUM_RD,
    S_SUM_WR,
    S_NRM_CAPT,
    S_NRM_SHIFT,
    S_NRM_SQ,
    S_SQRT,
    S_DIV_INIT,
    S_DIV,
    S_FINISH
  } state_t;

endpackage

// ----- rtl/vertex_normal_accumulator.sv -----
// Area-weighted vertex normal accumulator with position and sum memories.
// A read of a nonzero normal shifts the sums down, squares them, takes a square
// root and performs three divisions; one item is in flight at a time, as the
// input stalls whenever the block is not idle. A clear walks the sum memory once.
// The same pass runs after reset, during which no transaction is taken on the
// input channel.
module vertex_normal_accumulator #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 20
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vna_pkg::VCNT_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [vna_pkg::CMD_W-1:0]            cmd,
  input  logic [vna_pkg::IDX_W-1:0]            slot,
  input  logic signed [vna_pkg::POS_W-1:0]     pos_x,
  input  logic signed [vna_pkg::POS_W-1:0]     pos_y,
  input  logic signed [vna_pkg::POS_W-1:0]     pos_z,
  input  logic [vna_pkg::IDX_W-1:0]            corner_a,
  input  logic [vna_pkg::IDX_W-1:0]            corner_b,
  input  logic [vna_pkg::IDX_W-1:0]            corner_c,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 status,
  output logic signed [vna_pkg::NORM_W-1:0]    norm_x,
  output logic signed [vna_pkg::NORM_W-1:0]    norm_y,
  output logic signed [vna_pkg::NORM_W-1:0]    norm_z,
  output logic                                 degenerate
);

  localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CB  = COORD_BITS;
  localparam int DW  = CB + 1;
  localparam int PW  = 2 * DW;
  localparam int NW  = PW + 1;
  localparam int PMW = 3 * CB;
  localparam int SMW = 3 * vna_pkg::SUM_W;
  localparam int SW  = vna_pkg::SUM_W;

  // Storage: positions are undefined until loaded; sums are cleared by a sweep.
  logic [PMW-1:0] pos_mem [MAX_VERTICES];
  logic [SMW-1:0] sum_mem [MAX_VERTICES];

  logic           pos_we;
  logic [AW-1:0]  pos_waddr, pos_raddr;
  logic [PMW-1:0] pos_wdata, pos_rdata;
  logic           sum_we;
  logic [AW-1:0]  sum_waddr, sum_raddr;
  logic [SMW-1:0] sum_wdata, sum_rdata;

  vna_pkg::state_t state, state_next;

  // Item registers captured at the input transaction.
  logic [vna_pkg::CMD_W-1:0] cmd_r;
  logic [vna_pkg::IDX_W-1:0] slot_r, ca_r, cb_r, cc_r;
  logic [CB-1:0]             px_r, py_r, pz_r;

  logic [vna_pkg::VCNT_W-1:0] vertex_count;
  logic [AW-1:0]              clr_cnt;
  logic                       clr_reply;
  logic [vna_pkg::CNT_W-1:0]  cnt;

  // Triangle datapath.
  logic [PMW-1:0]        pv [3];
  logic signed [DW-1:0]  ab [3];
  logic signed [DW-1:0]  ac [3];
  logic signed [DW-1:0]  opa, opb;
  logic signed [PW-1:0]  prod;
  logic signed [NW-1:0]  nr [3];
  logic [vna_pkg::CNT_W-1:0] prev;

  // Normalization datapath.
  logic [SW-1:0]            tmag [3];
  logic                     sneg [3];
  logic [2*vna_pkg::T_W-1:0] sq_prod;
  logic [vna_pkg::SQ_W-1:0] sq_v, sq_r, sq_bit, sq_try;
  logic [vna_pkg::LEN_W-1:0] len;
  logic [vna_pkg::DV_W-1:0] rem, dsub;
  logic [vna_pkg::QUO_W-1:0] quo;
  logic [3:0]               dbit;
  logic signed [vna_pkg::NORM_W-1:0] res_n [3];
  logic                     res_status, res_degen;

  logic [vna_pkg::LIM_W-1:0] lim;
  logic                      slot_bad, tri_bad;
  logic                      in_take, out_load;

  function automatic logic [AW-1:0] to_addr(input logic [vna_pkg::IDX_W-1:0] i);
    logic [31:0] e;
    e = 32'(i);
    return e[AW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] coord(input logic [PMW-1:0] w,
                                                 input int j);
    logic [CB-1:0] c;
    c = w[j*CB +: CB];
    return $signed({c[CB-1], c});
  endfunction

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a,
                                            input logic signed [NW-1:0] n);
    logic [SW:0] s;
    s = {a[SW-1], a} + (SW+1)'(n);
    if (s[SW] != s[SW-1]) begin
      return s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    return s[SW-1:0];
  endfunction

  function automatic logic [SW-1:0] magn(input logic [SW-1:0] v);
    return v[SW-1] ? (~v + SW'(1)) : v;
  endfunction

  // Memories: one write and one registered read port each.
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_rdata <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_rdata <= sum_mem[sum_raddr];
  end

  // Range checks against the effective vertex count.
  always_comb begin
    if (vna_pkg::LIM_W'(vertex_count) > vna_pkg::LIM_W'(MAX_VERTICES)) begin
      lim = vna_pkg::LIM_W'(MAX_VERTICES);
    end else begin
      lim = vna_pkg::LIM_W'(vertex_count);
    end
    slot_bad = vna_pkg::LIM_W'(slot_r) >= lim;
    tri_bad  = (vna_pkg::LIM_W'(ca_r) >= lim) || (vna_pkg::LIM_W'(cb_r) >= lim) ||
               (vna_pkg::LIM_W'(cc_r) >= lim);
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != vna_pkg::S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_load  = (state == vna_pkg::S_FINISH) && (!out_valid || !out_stall);
  assign prev      = cnt - vna_pkg::CNT_W'(1);

  // Cross product operands: even steps load a component, odd steps subtract from it.
  always_comb begin
    unique case (cnt)
      3'd0:    begin opa = ab[1]; opb = ac[2]; end
      3'd1:    begin opa = ab[2]; opb = ac[1]; end
      3'd2:    begin opa = ab[2]; opb = ac[0]; end
      3'd3:    begin opa = ab[0]; opb = ac[2]; end
      3'd4:    begin opa = ab[0]; opb = ac[1]; end
      default: begin opa = ab[1]; opb = ac[0]; end
    endcase
  end

  assign sq_try = sq_r + sq_bit;
  assign dsub   = vna_pkg::DV_W'(len) << dbit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vna_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory port control.
  always_comb begin
    logic [vna_pkg::IDX_W-1:0] corner;
    unique case (cnt[1:0])
      2'd0:    corner = ca_r;
      2'd1:    corner = cb_r;
      default: corner = cc_r;
    endcase
    state_next = state;
    pos_we     = 1'b0;
    pos_waddr  = to_addr(slot_r);
    pos_wdata  = {pz_r, py_r, px_r};
    pos_raddr  = to_addr(corner);
    sum_we     = 1'b0;
    sum_waddr  = to_addr(corner);
    sum_wdata  = {sat_add(sum_rdata[2*SW +: SW], nr[2]),
                  sat_add(sum_rdata[SW +: SW], nr[1]),
                  sat_add(sum_rdata[0 +: SW], nr[0])};
    sum_raddr  = to_addr(corner);
    unique case (state)
      vna_pkg::S_CLEAR: begin
        sum_we    = 1'b1;
        sum_waddr = clr_cnt;
        sum_wdata = '0;
        if (clr_cnt == AW'(MAX_VERTICES - 1)) begin
          state_next = clr_reply ? vna_pkg::S_FINISH : vna_pkg::S_IDLE;
        end
      end
      vna_pkg::S_IDLE: begin
        if (in_take) begin
          state_next = vna_pkg::S_DECODE;
        end
      end
      vna_pkg::S_DECODE: begin
        sum_raddr = to_addr(slot_r);
        unique case (vna_pkg::cmd_t'(cmd_r))
          vna_pkg::CMD_CLEAR: state_next = vna_pkg::S_CLEAR;
          vna_pkg::CMD_LOAD: begin
            pos_we     = !slot_bad;
            state_next = vna_pkg::S_FINISH;
          end
          vna_pkg::CMD_TRI: begin
            state_next = tri_bad ? vna_pkg::S_FINISH : vna_pkg::S_TRI_RD;
          end
          default: begin
            state_next = slot_bad ? vna_pkg::S_FINISH : vna_pkg::S_NRM_CAPT;
          end
        endcase
      end
      vna_pkg::S_TRI_RD: begin
        if (cnt == 3'd3) state_next = vna_pkg::S_TRI_DIFF;
      end
      vna_pkg::S_TRI_DIFF: state_next = vna_pkg::S_TRI_MUL;
      vna_pkg::S_TRI_MUL: begin
        if (cnt == 3'd6) state_next = vna_pkg::S_SUM_RD;
      end
      vna_pkg::S_SUM_RD: state_next = vna_pkg::S_SUM_WR;
      vna_pkg::S_SUM_WR: begin
        sum_we     = 1'b1;
        state_next = (cnt == 3'd2) ? vna_pkg::S_FINISH : vna_pkg::S_SUM_RD;
      end
      vna_pkg::S_NRM_CAPT: begin
        if (sum_rdata == '0) begin
          state_next = vna_pkg::S_FINISH;
        end else begin
          state_next = vna_pkg::S_NRM_SHIFT;
        end
      end
      vna_pkg::S_NRM_SHIFT: begin
        if (tmag[0][SW-1:vna_pkg::T_W] == '0 && tmag[1][SW-1:vna_pkg::T_W] == '0 &&
            tmag[2][SW-1:vna_pkg::T_W] == '0) begin
          state_next = vna_pkg::S_NRM_SQ;
        end
      end
      vna_pkg::S_NRM_SQ: begin
        if (cnt == 3'd3) state_next = vna_pkg::S_SQRT;
      end
      vna_pkg::S_SQRT: begin
        if (sq_bit == '0) state_next = vna_pkg::S_DIV_INIT;
      end
      vna_pkg::S_DIV_INIT: state_next = vna_pkg::S_DIV;
      vna_pkg::S_DIV: begin
        if (dbit == 4'd0) begin
          state_next = (cnt == 3'd2) ? vna_pkg::S_FINISH : vna_pkg::S_DIV_INIT;
        end
      end
      vna_pkg::S_FINISH: begin
        if (out_load) state_next = vna_pkg::S_IDLE;
      end
      default: state_next = vna_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      clr_cnt      <= '0;
      clr_reply    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      if (state == vna_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
        if (clr_cnt == AW'(MAX_VERTICES - 1)) clr_cnt <= '0;
      end
      if (state == vna_pkg::S_DECODE) begin
        clr_reply <= (cmd_r == vna_pkg::CMD_CLEAR);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register toward the output channel.
  always_ff @(posedge clk) begin
    if (out_load) begin
      status     <= res_status;
      norm_x     <= res_n[0];
      norm_y     <= res_n[1];
      norm_z     <= res_n[2];
      degenerate <= res_degen;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r  <= cmd;
      slot_r <= slot;
      ca_r   <= corner_a;
      cb_r   <= corner_b;
      cc_r   <= corner_c;
      px_r   <= CB'(vna_pkg::POS_EXT'($unsigned(pos_x)));
      py_r   <= CB'(vna_pkg::POS_EXT'($unsigned(pos_y)));
      pz_r   <= CB'(vna_pkg::POS_EXT'($unsigned(pos_z)));
    end
    unique case (state)
      vna_pkg::S_DECODE: begin
        cnt        <= '0;
        res_n[0]   <= '0;
        res_n[1]   <= '0;
        res_n[2]   <= '0;
        res_degen  <= 1'b0;
        res_status <= 1'b0;
        if ((cmd_r == vna_pkg::CMD_TRI && tri_bad) ||
            ((cmd_r == vna_pkg::CMD_LOAD || cmd_r == vna_pkg::CMD_READ) && slot_bad)) begin
          res_status <= 1'b1;
        end
      end
      vna_pkg::S_TRI_RD: begin
        cnt <= cnt + vna_pkg::CNT_W'(1);
        if (cnt != '0) pv[prev[1:0]] <= pos_rdata;
      end
      vna_pkg::S_TRI_DIFF: begin
        for (int j = 0; j < 3; j++) begin
          ab[j] <= coord(pv[1], j) - coord(pv[0], j);
          ac[j] <= coord(pv[2], j) - coord(pv[0], j);
        end
        cnt <= '0;
      end
      vna_pkg::S_TRI_MUL: begin
        prod <= opa * opb;
        if (cnt != '0) begin
          if (!prev[0]) begin
            nr[prev[2:1]] <= NW'(prod);
          end else begin
            nr[prev[2:1]] <= nr[prev[2:1]] - NW'(prod);
          end
        end
        cnt <= (cnt == 3'd6) ? '0 : cnt + vna_pkg::CNT_W'(1);
      end
      vna_pkg::S_SUM_WR: begin
        cnt <= cnt + vna_pkg::CNT_W'(1);
      end
      vna_pkg::S_NRM_CAPT: begin
        for (int j = 0; j < 3; j++) begin
          tmag[j] <= magn(sum_rdata[j*SW +: SW]);
          sneg[j] <= sum_rdata[j*SW + SW - 1];
        end
        if (sum_rdata == '0) begin
          res_degen <= 1'b1;
          res_n[2]  <= vna_pkg::ONE_Q14;
        end
      end
      vna_pkg::S_NRM_SHIFT: begin
        if (state_next == vna_pkg::S_NRM_SHIFT) begin
          for (int j = 0; j < 3; j++) tmag[j] <= tmag[j] >> 1;
        end
        cnt    <= '0;
        sq_v   <= '0;
        sq_r   <= '0;
        sq_bit <= vna_pkg::SQ_W'(1) << (vna_pkg::SQ_W - 2);
      end
      vna_pkg::S_NRM_SQ: begin
        sq_prod <= tmag[cnt[1:0]][vna_pkg::T_W-1:0] * tmag[cnt[1:0]][vna_pkg::T_W-1:0];
        if (cnt != '0) sq_v <= sq_v + vna_pkg::SQ_W'(sq_prod);
        cnt <= (cnt == 3'd3) ? '0 : cnt + vna_pkg::CNT_W'(1);
      end
      vna_pkg::S_SQRT: begin
        if (sq_bit != '0) begin
          if (sq_v >= sq_try) begin
            sq_v <= sq_v - sq_try;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end else begin
          len <= (sq_r == '0) ? vna_pkg::LEN_W'(1) : sq_r[vna_pkg::LEN_W-1:0];
        end
      end
      vna_pkg::S_DIV_INIT: begin
        rem  <= (vna_pkg::DV_W'(tmag[cnt[1:0]][vna_pkg::T_W-1:0]) << vna_pkg::FRAC_Q) +
                vna_pkg::DV_W'(len >> 1);
        quo  <= '0;
        dbit <= 4'(vna_pkg::QUO_W - 1);
      end
      vna_pkg::S_DIV: begin
        logic [vna_pkg::QUO_W-1:0] qn;
        qn = quo;
        if (rem >= dsub) begin
          rem      <= rem - dsub;
          qn[dbit] = 1'b1;
        end
        quo  <= qn;
        dbit <= dbit - 4'd1;
        if (dbit == 4'd0) begin
          res_n[cnt[1:0]] <= sneg[cnt[1:0]] ? -$signed(vna_pkg::NORM_W'(qn))
                                            : $signed(vna_pkg::NORM_W'(qn));
          cnt <= cnt + vna_pkg::CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // A failed range check never reports a normal.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> norm_x == 0 && norm_y == 0 && norm_z == 0 && !degenerate)
    else $error("error result carries a normal");

  // A degenerate read reports the fixed up vector.
  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> norm_x == 0 && norm_y == 0 &&
      norm_z == $signed(vna_pkg::ONE_Q14) && !status)
    else $error("degenerate result malformed");

  // The sum memory is written only by the clear sweep or a triangle update.
  a_sum_we: assert property (@(posedge clk) disable iff (rst)
    sum_we |-> state == vna_pkg::S_CLEAR || state == vna_pkg::S_SUM_WR)
    else $error("unexpected sum memory write");

  // The divider never sees a zero length.
  a_len: assert property (@(posedge clk) disable iff (rst)
    state == vna_pkg::S_DIV |-> len != 0)
    else $error("zero length in divider");

endmodule

// ----- bench/tb_vertex_normal_accumulator.sv -----
// Self-checking testbench of the vertex normal accumulator.
module tb_vertex_normal_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     SLOTS      = 1024;
  localparam longint SUM_HI     = 64'sh007F_FFFF_FFFF_FFFF;
  localparam longint SUM_LO     = -SUM_HI - 1;
  localparam longint CYCLE_CAP  = 1000000;
  localparam int     BIG_TRIS   = 100;
  localparam int     RAND_ITEMS = 250;

  // One result transaction as the block returns it.
  typedef struct packed {
    logic                              st;
    logic signed [vna_pkg::NORM_W-1:0] nx;
    logic signed [vna_pkg::NORM_W-1:0] ny;
    logic signed [vna_pkg::NORM_W-1:0] nz;
    logic                              dg;
  } normal_t;

  // One row of the directed stimulus table. Rows with known set carry a
  // hand-written result; all other rows take the predicted one.
  typedef struct {
    vna_pkg::cmd_t                    op;
    logic [vna_pkg::IDX_W-1:0]        sl;
    logic signed [vna_pkg::POS_W-1:0] px, py, pz;
    logic [vna_pkg::IDX_W-1:0]        ca, cb, cc;
    bit                               known;
    normal_t                          want;
  } row_t;

  logic                              clk;
  logic                              rst;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [vna_pkg::VCNT_W-1:0]        cfg_data;
  logic                              in_valid;
  logic                              in_stall;
  logic [vna_pkg::CMD_W-1:0]         cmd;
  logic [vna_pkg::IDX_W-1:0]         slot;
  logic signed [vna_pkg::POS_W-1:0]  pos_x, pos_y, pos_z;
  logic [vna_pkg::IDX_W-1:0]         corner_a, corner_b, corner_c;
  logic                              out_valid;
  logic                              out_stall;
  logic                              status;
  logic signed [vna_pkg::NORM_W-1:0] norm_x, norm_y, norm_z;
  logic                              degenerate;

  vertex_normal_accumulator uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .slot       (slot),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .corner_a   (corner_a),
    .corner_b   (corner_b),
    .corner_c   (corner_c),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .norm_x     (norm_x),
    .norm_y     (norm_y),
    .norm_z     (norm_z),
    .degenerate (degenerate)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the block's state, kept by the predictor.
  int      vtx_x [SLOTS];
  int      vtx_y [SLOTS];
  int      vtx_z [SLOTS];
  bit      vtx_loaded [SLOTS];
  longint  acc_x [SLOTS];
  longint  acc_y [SLOTS];
  longint  acc_z [SLOTS];
  int      slot_limit;

  normal_t pending_normals[$];
  row_t    plan[$];
  int      errors;
  longint  cycles;
  int      sender_idle_pct;
  int      recv_idle_pct;
  int      hold_request;
  int      hold_left;
  normal_t oldest;

  // Integer square root, bit by bit, as the block computes it.
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clamp_add(input longint a, input longint b);
    longint s;
    s = a + b;
    if (s > SUM_HI) return SUM_HI;
    if (s < SUM_LO) return SUM_LO;
    return s;
  endfunction

  // Applies one transaction to the shadow state and returns the result that
  // the block must produce for it.
  function automatic normal_t predict_normal(input vna_pkg::cmd_t op,
                                             input logic [vna_pkg::IDX_W-1:0] sl,
                                             input logic signed [vna_pkg::POS_W-1:0] x, y, z,
                                             input logic [vna_pkg::IDX_W-1:0] a, b, c);
    normal_t     r;
    longint      abx, aby, abz, acx, acy, acz, fx, fy, fz;
    longint      s [3];
    logic [63:0] t [3];
    logic [63:0] m, q, len, q14;
    int          k;
    int          v;
    r = '0;
    case (op)
      vna_pkg::CMD_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          acc_x[i] = 0;
          acc_y[i] = 0;
          acc_z[i] = 0;
        end
      end
      vna_pkg::CMD_LOAD: begin
        if (sl >= slot_limit) begin
          r.st = 1'b1;
        end else begin
          vtx_x[sl] = int'(x);
          vtx_y[sl] = int'(y);
          vtx_z[sl] = int'(z);
          vtx_loaded[sl] = 1'b1;
        end
      end
      vna_pkg::CMD_TRI: begin
        if (a >= slot_limit || b >= slot_limit || c >= slot_limit) begin
          r.st = 1'b1;
        end else begin
          abx = longint'(vtx_x[b]) - vtx_x[a];
          aby = longint'(vtx_y[b]) - vtx_y[a];
          abz = longint'(vtx_z[b]) - vtx_z[a];
          acx = longint'(vtx_x[c]) - vtx_x[a];
          acy = longint'(vtx_y[c]) - vtx_y[a];
          acz = longint'(vtx_z[c]) - vtx_z[a];
          fx = aby * acz - abz * acy;
          fy = abz * acx - abx * acz;
          fz = abx * acy - aby * acx;
          // Every listed corner takes the face normal, repeats included.
          for (int j = 0; j < 3; j++) begin
            v = int'((j == 0) ? a : (j == 1) ? b : c);
            acc_x[v] = clamp_add(acc_x[v], fx);
            acc_y[v] = clamp_add(acc_y[v], fy);
            acc_z[v] = clamp_add(acc_z[v], fz);
          end
        end
      end
      default: begin
        if (sl >= slot_limit) begin
          r.st = 1'b1;
        end else begin
          s[0] = acc_x[sl];
          s[1] = acc_y[sl];
          s[2] = acc_z[sl];
          if (s[0] == 0 && s[1] == 0 && s[2] == 0) begin
            r.nz = vna_pkg::ONE_Q14;
            r.dg = 1'b1;
          end else begin
            m = 0;
            for (int j = 0; j < 3; j++) begin
              t[j] = (s[j] < 0) ? -s[j] : s[j];
              if (t[j] > m) m = t[j];
            end
            k = 0;
            while ((m >> k) >= (64'd1 << vna_pkg::T_W)) k++;
            q = 0;
            for (int j = 0; j < 3; j++) begin
              t[j] = t[j] >> k;
              q = q + t[j] * t[j];
            end
            len = int_sqrt(q);
            if (len == 0) len = 1;
            for (int j = 0; j < 3; j++) begin
              q14 = (t[j] * 64'd16384 + len / 2) / len;
              if (s[j] < 0) q14 = -q14;
              if (j == 0) r.nx = q14[vna_pkg::NORM_W-1:0];
              else if (j == 1) r.ny = q14[vna_pkg::NORM_W-1:0];
              else r.nz = q14[vna_pkg::NORM_W-1:0];
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // Result side: compares every accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_normals.size() == 0) begin
        report_mismatch("unexpected result, status", status, 0);
      end else begin
        oldest = pending_normals.pop_front();
        if (status !== oldest.st) report_mismatch("status", status, oldest.st);
        if (norm_x !== oldest.nx) report_mismatch("norm_x", norm_x, oldest.nx);
        if (norm_y !== oldest.ny) report_mismatch("norm_y", norm_y, oldest.ny);
        if (norm_z !== oldest.nz) report_mismatch("norm_z", norm_z, oldest.nz);
        if (degenerate !== oldest.dg) report_mismatch("degenerate", degenerate, oldest.dg);
      end
    end
  end

  // Receiver stalls. A long hold-off requested by the sender is counted here,
  // in cycles, so the block backs up and stalls its own input.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offers one transaction and holds it until accepted. Valid stays high into
  // the next transaction unless the sender decides to idle.
  task automatic send_item(input row_t it);
    normal_t r;
    in_valid <= 1'b1;
    cmd      <= it.op;
    slot     <= it.sl;
    pos_x    <= it.px;
    pos_y    <= it.py;
    pos_z    <= it.pz;
    corner_a <= it.ca;
    corner_b <= it.cb;
    corner_c <= it.cc;
    do @(posedge clk); while (in_stall);
    r = predict_normal(it.op, it.sl, it.px, it.py, it.pz, it.ca, it.cb, it.cc);
    pending_normals.push_back(it.known ? it.want : r);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_vertex_count(input int unsigned value);
    drain_results();
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value[vna_pkg::VCNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // A count above the capacity acts as the capacity.
    slot_limit = (value > SLOTS) ? SLOTS : value;
  endtask

  function automatic void add_row(input vna_pkg::cmd_t op, input int sl,
                                  input int px, py, pz,
                                  input int ca, cb, cc, input bit known,
                                  input normal_t want);
    row_t r;
    r.op = op;
    r.sl = vna_pkg::IDX_W'(sl);
    r.px = vna_pkg::POS_W'(px);
    r.py = vna_pkg::POS_W'(py);
    r.pz = vna_pkg::POS_W'(pz);
    r.ca = vna_pkg::IDX_W'(ca);
    r.cb = vna_pkg::IDX_W'(cb);
    r.cc = vna_pkg::IDX_W'(cc);
    r.known = known;
    r.want = want;
    plan.push_back(r);
  endfunction

  function automatic int random_coord();
    case ($urandom_range(5))
      0:       return -524288;
      1:       return 524287;
      2:       return $urandom_range(0, 2047) - 1024;
      default: return $signed($urandom_range(0, 1048575) << 12) >>> 12;
    endcase
  endfunction

  // A loaded corner in range, found in up to 64 random tries; else slot zero.
  function automatic int loaded_corner();
    int c;
    for (int tries = 0; tries < 64; tries++) begin
      c = $urandom_range(slot_limit - 1);
      if (vtx_loaded[c]) return c;
    end
    return 0;
  endfunction

  function automatic row_t random_row();
    row_t r;
    int   pick;
    int   noisy;
    r.known = 1'b0;
    r.want  = '0;
    r.px = vna_pkg::POS_W'(random_coord());
    r.py = vna_pkg::POS_W'(random_coord());
    r.pz = vna_pkg::POS_W'(random_coord());
    r.sl = vna_pkg::IDX_W'($urandom_range(SLOTS - 1));
    r.ca = vna_pkg::IDX_W'(loaded_corner());
    r.cb = vna_pkg::IDX_W'(loaded_corner());
    r.cc = vna_pkg::IDX_W'(loaded_corner());
    pick = $urandom_range(99);
    if (pick < 2) begin
      r.op = vna_pkg::CMD_CLEAR;
    end else if (pick < 32) begin
      r.op = vna_pkg::CMD_LOAD;
      if ($urandom_range(9) != 0) r.sl = vna_pkg::IDX_W'($urandom_range(slot_limit - 1));
    end else if (pick < 77) begin
      r.op = vna_pkg::CMD_TRI;
      // Occasional corner anywhere in the index range; never an unloaded one.
      if ($urandom_range(9) == 0) begin
        noisy = $urandom_range(SLOTS - 1);
        if (noisy < slot_limit && !vtx_loaded[noisy]) noisy = 0;
        case ($urandom_range(2))
          0:       r.ca = vna_pkg::IDX_W'(noisy);
          1:       r.cb = vna_pkg::IDX_W'(noisy);
          default: r.cc = vna_pkg::IDX_W'(noisy);
        endcase
      end
      if ($urandom_range(19) == 0) r.cc = r.ca;
    end else begin
      r.op = vna_pkg::CMD_READ;
      if ($urandom_range(9) != 0) r.sl = vna_pkg::IDX_W'($urandom_range(slot_limit - 1));
    end
    return r;
  endfunction

  task automatic random_phase(input int unsigned count, input int snd, input int rcv,
                              input int items);
    write_vertex_count(count);
    sender_idle_pct = snd;
    recv_idle_pct = rcv;
    for (int i = 0; i < items; i++) begin
      if (i == items / 3) hold_request = 400;
      if (i == 2 * items / 3) drain_results();
      send_item(random_row());
    end
  endtask

  initial begin
    normal_t ok, err, unit_z, flat;
    row_t    big_tri;
    errors = 0;
    cycles = 0;
    hold_request = 0;
    hold_left = 0;
    sender_idle_pct = 34;
    recv_idle_pct = 60;
    for (int i = 0; i < SLOTS; i++) begin
      vtx_x[i] = 0;
      vtx_y[i] = 0;
      vtx_z[i] = 0;
      vtx_loaded[i] = 1'b0;
      acc_x[i] = 0;
      acc_y[i] = 0;
      acc_z[i] = 0;
    end
    slot_limit = 0;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    cmd       <= vna_pkg::CMD_CLEAR;
    slot      <= '0;
    pos_x     <= '0;
    pos_y     <= '0;
    pos_z     <= '0;
    corner_a  <= '0;
    corner_b  <= '0;
    corner_c  <= '0;
    out_stall <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    ok = '0;
    err = '0;
    err.st = 1'b1;
    unit_z = '0;
    unit_z.nz = vna_pkg::ONE_Q14;
    unit_z.dg = 1'b1;
    flat = '0;

    // With the count still zero after reset, every slot is out of range.
    add_row(vna_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1'b1, err);
    add_row(vna_pkg::CMD_LOAD, 0, 1, 2, 3, 0, 0, 0, 1'b1, err);
    add_row(vna_pkg::CMD_TRI, 0, 0, 0, 0, 0, 0, 0, 1'b1, err);
    add_row(vna_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1'b1, ok);
    foreach (plan[i]) send_item(plan[i]);
    plan.delete();

    write_vertex_count(8);
    add_row(vna_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1'b1, unit_z);
    add_row(vna_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0, 0, 1'b1, ok);
    add_row(vna_pkg::CMD_LOAD, 1, 524287, 0, 0, 0, 0, 0, 1'b1, ok);
    add_row(vna_pkg::CMD_LOAD, 2, 0, -524288, 0, 0, 0, 0, 1'b1, ok);
    add_row(vna_pkg::CMD_LOAD, 3, -524288, -524288, -524288, 0, 0, 0, 1'b1, ok);
    add_row(vna_pkg::CMD_LOAD, 4, 524287, 524287, 524287, 0, 0, 0, 1'b1, ok);
    add_row(vna_pkg::CMD_LOAD, 7, -1, 1, -1024, 0, 0, 0, 1'b1, ok);
    add_row(vna_pkg::CMD_LOAD, 8, 5, 5, 5, 0, 0, 0, 1'b1, err);
    add_row(vna_pkg::CMD_LOAD, 1023, 5, 5, 5, 0, 0, 0, 1'b1, err);
    add_row(vna_pkg::CMD_TRI, 0, 0, 0, 0, 0, 1, 2, 1'b0, flat);
    add_row(vna_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, flat);
    add_row(vna_pkg::CMD_TRI, 0, 0, 0, 0, 3, 4, 7, 1'b0, flat);
    // Repeated corners: each listed corner receives the face normal.
    add_row(vna_pkg::CMD_TRI, 0, 0, 0, 0, 1, 1, 2, 1'b0, flat);
    add_row(vna_pkg::CMD_TRI, 0, 0, 0, 0, 0, 1, 8, 1'b1, err);
    add_row(vna_pkg::CMD_TRI, 0, 0, 0, 0, 1023, 1, 2, 1'b1, err);
    add_row(vna_pkg::CMD_READ, 3, 0, 0, 0, 0, 0, 0, 1'b0, flat);
    add_row(vna_pkg::CMD_READ, 7, 0, 0, 0, 0, 0, 0, 1'b0, flat);
    add_row(vna_pkg::CMD_READ, 1023, 0, 0, 0, 0, 0, 0, 1'b1, err);
    add_row(vna_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1'b1, ok);
    add_row(vna_pkg::CMD_READ, 1, 0, 0, 0, 0, 0, 0, 1'b1, unit_z);
    foreach (plan[i]) send_item(plan[i]);
    plan.delete();

    // Large sums: one large triangle repeated so that its corners grow far
    // past the square root width and the read must shift them down.
    write_vertex_count(1024);
    sender_idle_pct = 0;
    recv_idle_pct = 0;
    add_row(vna_pkg::CMD_LOAD, 1000, -524288, 0, 0, 0, 0, 0, 1'b0, flat);
    add_row(vna_pkg::CMD_LOAD, 1001, 524287, 524287, 0, 0, 0, 0, 1'b0, flat);
    add_row(vna_pkg::CMD_LOAD, 1002, 524287, -524288, 0, 0, 0, 0, 1'b0, flat);
    foreach (plan[i]) send_item(plan[i]);
    plan.delete();
    big_tri.op = vna_pkg::CMD_TRI;
    big_tri.sl = '0;
    big_tri.px = '0;
    big_tri.py = '0;
    big_tri.pz = '0;
    big_tri.ca = vna_pkg::IDX_W'(1000);
    big_tri.cb = vna_pkg::IDX_W'(1001);
    big_tri.cc = vna_pkg::IDX_W'(1002);
    big_tri.known = 1'b0;
    big_tri.want = '0;
    for (int i = 0; i < BIG_TRIS; i++) send_item(big_tri);
    big_tri.op = vna_pkg::CMD_READ;
    big_tri.sl = vna_pkg::IDX_W'(1001);
    send_item(big_tri);

    // Random part over several counts, including the capacity and above it, with
    // sender and receiver idle rates of 34/60 and 60/34 percent, then none.
    random_phase(1024, 34, 60, RAND_ITEMS);
    random_phase(2047, 60, 34, RAND_ITEMS);
    random_phase(3, 0, 0, RAND_ITEMS / 2);
    random_phase($urandom_range(4, 1023), 0, 0, RAND_ITEMS);

    drain_results();
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_normals.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/vna_pkg.sv
rtl/vertex_normal_accumulator.sv
bench/tb_vertex_normal_accumulator.sv
